// ===== design/buddy_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");

`endif

// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Sizes, operation and status codes, controller/datapath types and helpers.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_PAGES  = 1024;
	localparam int TREE_NODES = 2 * MAX_PAGES;
	localparam int PAGE_W     = 11;
	localparam int OFF_W      = 10;
	localparam int WANT_W     = PAGE_W + 1;
	localparam int IDX_W      = $clog2(TREE_NODES);

	localparam logic [PAGE_W-1:0] RESET_POOL = PAGE_W'(MAX_PAGES);

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
	localparam logic [1:0] ST_OUT_POOL = 2'd3;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_A_INIT,
		DP_A_STEP,
		DP_CLIMB,
		DP_FOUND,
		DP_MARK,
		DP_UP,
		DP_RESULT,
		DP_OUT,
		DP_CLR_INIT,
		DP_CLR_STEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] res;
	} bba_cmd_t;

	typedef struct packed {
		logic       cfg_ok;
		logic [1:0] in_kind;
		logic [1:0] kind;
		logic       root_short;
		logic       pool_is_want;
		logic       half_is_want;
		logic       oob;
		logic       node_zero;
		logic       at_root;
		logic       clr_last;
	} bba_sts_t;

	function automatic logic is_pow2(input logic [PAGE_W-1:0] v);
		return (v != '0) && ((v & (v - PAGE_W'(1))) == '0);
	endfunction

	// round up to a power of two, zero taken as one
	function automatic logic [WANT_W-1:0] round_pow2(input logic [PAGE_W-1:0] req);
		logic [PAGE_W-1:0] v;
		v = (req == '0) ? '0 : req - PAGE_W'(1);
		v = v | (v >> 1);
		v = v | (v >> 2);
		v = v | (v >> 4);
		v = v | (v >> 8);
		return {1'b0, v} + WANT_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] child_l(input logic [IDX_W-1:0] x);
		return {x[IDX_W-2:0], 1'b1};
	endfunction

	function automatic logic [IDX_W-1:0] child_r(input logic [IDX_W-1:0] x);
		return {x[IDX_W-2:0], 1'b0} + IDX_W'(2);
	endfunction

	function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] x);
		logic [IDX_W:0] p1;
		p1 = {1'b0, x} + (IDX_W+1)'(1);
		return p1[IDX_W:1] - IDX_W'(1);
	endfunction

endpackage

// ===== design/bba_if.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator channel interfaces
// Request, response and pool size write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic [bba_pkg::PAGE_W-1:0] req_pages;
	logic [bba_pkg::OFF_W-1:0]  page_offset;

	modport source (output valid, kind, req_pages, page_offset, input ready);
	modport sink (input valid, kind, req_pages, page_offset, output ready);
endinterface

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [bba_pkg::OFF_W-1:0]  block_offset;
	logic [bba_pkg::PAGE_W-1:0] block_pages;

	modport source (output valid, status, block_offset, block_pages, input ready);
	modport sink (input valid, status, block_offset, block_pages, output ready);
endinterface

interface bba_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::PAGE_W-1:0] pool_pages;

	modport source (output valid, pool_pages, input ready);
	modport sink (input valid, pool_pages, output ready);
endinterface

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences tree rebuild, descent, climb and parent update over the datapath.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bba_pkg::bba_sts_t sts,
	output bba_pkg::bba_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR   = 8'b0000_0001,
		S_IDLE    = 8'b0000_0010,
		S_A_CHK   = 8'b0000_0100,
		S_A_DESC  = 8'b0000_1000,
		S_F_CLIMB = 8'b0001_0000,
		S_MARK    = 8'b0010_0000,
		S_UP      = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE) && !cfg_valid;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = bba_pkg::DP_NOP;
		cmd.res = bba_pkg::ST_OK;
		if (cfg_valid && sts.cfg_ok) begin
			cmd.op  = bba_pkg::DP_CLR_INIT;
			state_d = S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cmd.op = bba_pkg::DP_CLR_STEP;
					if (sts.clr_last)
						state_d = S_IDLE;
				end
				S_IDLE: begin
					if (req_valid && req_ready) begin
						cmd.op = bba_pkg::DP_LOAD;
						case (sts.in_kind) inside
							bba_pkg::KIND_ALLOC: state_d = S_A_CHK;
							bba_pkg::KIND_FREE, bba_pkg::KIND_QUERY: state_d = S_F_CLIMB;
							default: state_d = S_DONE;
						endcase
					end
				end
				S_A_CHK: begin
					if (sts.root_short) begin
						cmd.op  = bba_pkg::DP_RESULT;
						cmd.res = bba_pkg::ST_NO_SPACE;
						state_d = S_DONE;
					end else begin
						cmd.op  = bba_pkg::DP_A_INIT;
						state_d = sts.pool_is_want ? S_MARK : S_A_DESC;
					end
				end
				S_A_DESC: begin
					cmd.op = bba_pkg::DP_A_STEP;
					if (sts.half_is_want)
						state_d = S_MARK;
				end
				S_F_CLIMB: begin
					if (sts.oob) begin
						cmd.op  = bba_pkg::DP_RESULT;
						cmd.res = bba_pkg::ST_OUT_POOL;
						state_d = S_DONE;
					end else if (sts.node_zero) begin
						cmd.op  = bba_pkg::DP_FOUND;
						state_d = (sts.kind == bba_pkg::KIND_FREE) ? S_MARK : S_DONE;
					end else if (sts.at_root) begin
						cmd.op  = bba_pkg::DP_RESULT;
						cmd.res = bba_pkg::ST_NOT_ALLOC;
						state_d = S_DONE;
					end else begin
						cmd.op = bba_pkg::DP_CLIMB;
					end
				end
				S_MARK: begin
					cmd.op  = bba_pkg::DP_MARK;
					state_d = sts.at_root ? S_DONE : S_UP;
				end
				S_UP: begin
					cmd.op = bba_pkg::DP_UP;
					if (sts.at_root)
						state_d = S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || rsp_ready) begin
						cmd.op  = bba_pkg::DP_OUT;
						state_d = S_IDLE;
					end
				end
				default: state_d = S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == bba_pkg::DP_OUT)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/bba_dpath.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Longest-free tree memory, node index and size registers, result registers.
// ----------------------------------------------------------------------------
module bba_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bba_pkg::bba_cmd_t           cmd,
	output bba_pkg::bba_sts_t           sts,
	input  logic [1:0]                  in_kind,
	input  logic [bba_pkg::PAGE_W-1:0] in_req_pages,
	input  logic [bba_pkg::OFF_W-1:0]  in_page_offset,
	input  logic [bba_pkg::PAGE_W-1:0] cfg_pool_pages,
	output logic [1:0]                  out_status,
	output logic [bba_pkg::OFF_W-1:0]  out_block_offset,
	output logic [bba_pkg::PAGE_W-1:0] out_block_pages
);

	localparam int PW = bba_pkg::PAGE_W;
	localparam int OW = bba_pkg::OFF_W;
	localparam int WW = bba_pkg::WANT_W;
	localparam int IW = bba_pkg::IDX_W;

	logic [PW-1:0] tree_mem [bba_pkg::TREE_NODES];
	logic [PW-1:0] rd_a_q, rd_b_q, byp_q;
	logic          hit_a_q, hit_b_q;

	logic [PW-1:0] pool_q;
	logic [IW-1:0] clr_cnt_q;
	logic [PW-1:0] clr_val_q;
	logic [IW:0]   clr_end_q;

	logic [1:0]    kind_q;
	logic [WW-1:0] want_q;
	logic [OW-1:0] off_q;
	logic [IW-1:0] idx_q;
	logic [PW-1:0] size_q;
	logic [OW-1:0] acc_q;
	logic [1:0]    res_status_q;
	logic [OW-1:0] res_off_q;
	logic [PW-1:0] res_pages_q;
	logic [1:0]    out_status_q;
	logic [OW-1:0] out_off_q;
	logic [PW-1:0] out_pages_q;

	logic [IW-1:0] ra, rb, wa;
	logic [PW-1:0] wd;
	logic          we;

	logic [PW-1:0] node_a, node_b;
	logic [IW-1:0] leaf, parent, next_idx;
	logic [PW-1:0] half;
	logic          l_fit, r_fit, go_r;
	logic [PW:0]   pair_sum;
	logic [PW-1:0] pair_max, up_val;

	// write-first forwarding of a same-cycle write
	assign node_a = hit_a_q ? byp_q : rd_a_q;
	assign node_b = hit_b_q ? byp_q : rd_b_q;

	assign leaf   = IW'(in_page_offset) + IW'(pool_q) - IW'(1);
	assign parent = bba_pkg::parent_of(idx_q);
	assign half   = size_q >> 1;

	// descent pick: smaller fitting child, left on a tie
	assign l_fit    = {1'b0, node_a} >= want_q;
	assign r_fit    = {1'b0, node_b} >= want_q;
	assign go_r     = (l_fit && r_fit) ? (node_b < node_a) : !l_fit;
	assign next_idx = go_r ? bba_pkg::child_r(idx_q) : bba_pkg::child_l(idx_q);

	assign pair_sum = {1'b0, node_a} + {1'b0, node_b};
	assign pair_max = (node_a > node_b) ? node_a : node_b;
	assign up_val   = (kind_q == bba_pkg::KIND_FREE && pair_sum == {1'b0, size_q}) ?
		size_q : pair_max;

	always_comb begin
		sts.cfg_ok       = bba_pkg::is_pow2(cfg_pool_pages);
		sts.in_kind      = in_kind;
		sts.kind         = kind_q;
		sts.root_short   = {1'b0, node_a} < want_q;
		sts.pool_is_want = {1'b0, pool_q} == want_q;
		sts.half_is_want = {1'b0, half} == want_q;
		sts.oob          = {1'b0, off_q} >= pool_q;
		sts.node_zero    = node_a == '0;
		sts.at_root      = idx_q == '0;
		sts.clr_last     = {1'b0, clr_cnt_q} == ({pool_q, 1'b0} - (IW+1)'(2));
	end

	always_comb begin
		ra = bba_pkg::child_l(parent);
		rb = bba_pkg::child_r(parent);
		we = 1'b0;
		wa = idx_q;
		wd = size_q;
		unique case (cmd.op)
			bba_pkg::DP_LOAD: begin
				ra = (in_kind == bba_pkg::KIND_ALLOC) ? '0 : leaf;
			end
			bba_pkg::DP_A_INIT: begin
				ra = bba_pkg::child_l('0);
				rb = bba_pkg::child_r('0);
			end
			bba_pkg::DP_A_STEP: begin
				ra = bba_pkg::child_l(next_idx);
				rb = bba_pkg::child_r(next_idx);
			end
			bba_pkg::DP_CLIMB: begin
				ra = parent;
			end
			bba_pkg::DP_MARK: begin
				we = 1'b1;
				wd = (kind_q == bba_pkg::KIND_ALLOC) ? '0 : size_q;
			end
			bba_pkg::DP_UP: begin
				we = 1'b1;
				wd = up_val;
			end
			bba_pkg::DP_CLR_STEP: begin
				we = 1'b1;
				wa = clr_cnt_q;
				wd = clr_val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			tree_mem[wa] <= wd;
		rd_a_q <= tree_mem[ra];
		rd_b_q <= tree_mem[rb];
		byp_q  <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_a_q   <= 1'b0;
			hit_b_q   <= 1'b0;
			pool_q    <= bba_pkg::RESET_POOL;
			clr_cnt_q <= '0;
			clr_val_q <= bba_pkg::RESET_POOL;
			clr_end_q <= '0;
		end else begin
			hit_a_q <= we && (ra == wa);
			hit_b_q <= we && (rb == wa);
			if (cmd.op == bba_pkg::DP_CLR_INIT) begin
				pool_q    <= cfg_pool_pages;
				clr_cnt_q <= '0;
				clr_val_q <= cfg_pool_pages;
				clr_end_q <= '0;
			end else if (cmd.op == bba_pkg::DP_CLR_STEP) begin
				clr_cnt_q <= clr_cnt_q + IW'(1);
				// halve the node value at the end of each tree level
				if ({1'b0, clr_cnt_q} == clr_end_q) begin
					clr_val_q <= clr_val_q >> 1;
					clr_end_q <= {clr_end_q[IW-1:0], 1'b0} + (IW+1)'(2);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bba_pkg::DP_LOAD: begin
				kind_q       <= in_kind;
				want_q       <= bba_pkg::round_pow2(in_req_pages);
				off_q        <= in_page_offset;
				idx_q        <= leaf;
				size_q       <= PW'(1);
				res_status_q <= bba_pkg::ST_OK;
				res_off_q    <= '0;
				res_pages_q  <= '0;
			end
			bba_pkg::DP_A_INIT: begin
				idx_q  <= '0;
				size_q <= pool_q;
				acc_q  <= '0;
			end
			bba_pkg::DP_A_STEP: begin
				idx_q  <= next_idx;
				size_q <= half;
				acc_q  <= acc_q + (go_r ? half[OW-1:0] : '0);
			end
			bba_pkg::DP_CLIMB: begin
				idx_q  <= parent;
				size_q <= {size_q[PW-2:0], 1'b0};
			end
			bba_pkg::DP_FOUND: begin
				res_pages_q <= size_q;
			end
			bba_pkg::DP_MARK: begin
				if (kind_q == bba_pkg::KIND_ALLOC) begin
					res_pages_q <= want_q[PW-1:0];
					res_off_q   <= acc_q;
				end
				idx_q  <= parent;
				size_q <= {size_q[PW-2:0], 1'b0};
			end
			bba_pkg::DP_UP: begin
				idx_q  <= parent;
				size_q <= {size_q[PW-2:0], 1'b0};
			end
			bba_pkg::DP_RESULT: begin
				res_status_q <= cmd.res;
				res_off_q    <= '0;
				res_pages_q  <= '0;
			end
			bba_pkg::DP_OUT: begin
				out_status_q <= res_status_q;
				out_off_q    <= res_off_q;
				out_pages_q  <= res_pages_q;
			end
			default: ;
		endcase
	end

	assign out_status       = out_status_q;
	assign out_block_offset = out_off_q;
	assign out_block_pages  = out_pages_q;

endmodule

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Power-of-two page allocator over a longest-free binary tree in one memory.
//
//   channel | dir | payload
//   cfg     | in  | pool_pages (write rebuilds the tree when a power of two)
//   req     | in  | kind, req_pages, page_offset
//   rsp     | out | status, block_offset, block_pages
//
// One request at a time; the engine walks the tree one level per step on the way
// down or up, with one memory access each.
// After reset and after each power-of-two pool write the tree is rewritten one
// node a cycle, all 2*pool_pages-1 nodes (2047 after reset); req is not taken.
// A finished response sits in the output register; the next request is taken
// while it waits, and the engine stalls at the end only if it is still held.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator (
	input  logic      clk,
	input  logic      arst_n,
	bba_cfg_if.sink   cfg,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);

	bba_pkg::bba_cmd_t cmd;
	bba_pkg::bba_sts_t sts;

	logic                       cfg_rebuild;
	logic                       rsp_ok, rsp_err, rsp_aligned;
	logic [bba_pkg::PAGE_W-1:0] blk_mask;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_kind          (req.kind),
		.in_req_pages     (req.req_pages),
		.in_page_offset   (req.page_offset),
		.cfg_pool_pages   (cfg.pool_pages),
		.out_status       (rsp.status),
		.out_block_offset (rsp.block_offset),
		.out_block_pages  (rsp.block_pages)
	);

	assign cfg_rebuild = cfg.valid && cfg.ready && bba_pkg::is_pow2(cfg.pool_pages);
	assign rsp_ok      = rsp.valid && rsp.status == bba_pkg::ST_OK;
	assign rsp_err     = rsp.valid && rsp.status != bba_pkg::ST_OK;
	assign blk_mask    = rsp.block_pages - bba_pkg::PAGE_W'(1);
	assign rsp_aligned = ({1'b0, rsp.block_offset} & blk_mask) == '0;

	`BBA_ASSERT_NEXT(a_cfg_rebuild, cfg_rebuild, !req.ready)
	`BBA_ASSERT_IMP(a_err_zero, rsp_err, rsp.block_pages == '0 && rsp.block_offset == '0)
	`BBA_ASSERT_IMP(a_ok_pow2, rsp_ok, $onehot0(rsp.block_pages))
	`BBA_ASSERT_IMP(a_ok_align, rsp_ok && rsp.block_pages != '0, rsp_aligned)

endmodule

// ===== test/tb_buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate, free and query requests over several pool sizes, predicts
// each response from a private copy of the longest-free tree and checks every
// response field in order. Both channel sides idle at random; one stretch
// runs without idling and one holds the response side off for a long time.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW = bba_pkg::PAGE_W;
	localparam int OW = bba_pkg::OFF_W;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [1:0]    kind;
		logic [PW-1:0] req_pages;
		logic [OW-1:0] page_offset;
	} op_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [OW-1:0] block_offset;
		logic [PW-1:0] block_pages;
	} outcome_t;

	typedef struct packed {
		logic [OW-1:0] offset;
		logic [PW-1:0] pages;
	} block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bba_cfg_if cfg_ch();
	bba_req_if req_ch();
	bba_rsp_if rsp_ch();

	buddy_block_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state: longest free run below each node, and current pool size
	logic [PW-1:0] longest_free [bba_pkg::TREE_NODES];
	logic [PW-1:0] pool_size;

	op_t      op_queue [$];
	outcome_t due_outcomes [$];
	block_t   held_blocks [$];

	bit req_taken = 1'b0;
	bit steady = 1'b0;
	int rsp_hold = 0;
	int fail_count = 0;
	int kind_count [4];
	int status_count [4];
	int pool_writes = 0;
	int pool_ignored = 0;
	int responses = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void rebuild_tree();
		int level_size;
		level_size = 2 * pool_size;
		for (int i = 0; i < 2 * pool_size - 1; i++) begin
			if (((i + 1) & i) == 0)
				level_size = level_size >> 1;
			longest_free[i] = PW'(level_size);
		end
	endfunction

	function automatic void apply_pool(input logic [PW-1:0] v);
		if (v != '0 && (v & (v - 1'b1)) == '0 && v <= bba_pkg::MAX_PAGES) begin
			pool_size = v;
			rebuild_tree();
			held_blocks.delete();
			pool_writes++;
		end else begin
			pool_ignored++;
		end
	endfunction

	function automatic int larger(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// work out the response to one accepted request and update the tree
	function automatic outcome_t allocator_outcome(input op_t op);
		outcome_t res;
		int want, node, level_size, lv, rv, span;
		bit found;
		res = '0;
		case (op.kind) inside
			bba_pkg::KIND_ALLOC: begin
				want = 1;
				while (want < op.req_pages)
					want = want << 1;
				if (longest_free[0] < want) begin
					res.status = bba_pkg::ST_NO_SPACE;
				end else begin
					node = 0;
					for (level_size = pool_size; level_size != want;
						level_size = level_size >> 1) begin
						lv = longest_free[2 * node + 1];
						rv = longest_free[2 * node + 2];
						if (lv >= want && rv >= want)
							node = (rv < lv) ? 2 * node + 2 : 2 * node + 1;
						else if (lv < want)
							node = 2 * node + 2;
						else
							node = 2 * node + 1;
					end
					longest_free[node] = '0;
					res.block_offset = OW'((node + 1) * level_size - pool_size);
					res.block_pages = PW'(want);
					held_blocks.push_back({res.block_offset, res.block_pages});
					while (node != 0) begin
						node = (node + 1) / 2 - 1;
						longest_free[node] = PW'(larger(longest_free[2 * node + 1],
							longest_free[2 * node + 2]));
					end
				end
			end
			bba_pkg::KIND_FREE, bba_pkg::KIND_QUERY: begin
				if (op.page_offset >= pool_size) begin
					res.status = bba_pkg::ST_OUT_POOL;
				end else begin
					// climb to the nearest used node
					node = op.page_offset + pool_size - 1;
					span = 1;
					found = 1'b1;
					while (longest_free[node] != '0) begin
						if (node == 0) begin
							found = 1'b0;
							break;
						end
						node = (node + 1) / 2 - 1;
						span = span << 1;
					end
					if (!found) begin
						res.status = bba_pkg::ST_NOT_ALLOC;
					end else begin
						res.block_pages = PW'(span);
						if (op.kind == bba_pkg::KIND_FREE) begin
							longest_free[node] = PW'(span);
							level_size = span;
							while (node != 0) begin
								node = (node + 1) / 2 - 1;
								level_size = level_size << 1;
								lv = longest_free[2 * node + 1];
								rv = longest_free[2 * node + 2];
								if (lv + rv == level_size)
									longest_free[node] = PW'(level_size);
								else
									longest_free[node] = PW'(larger(lv, rv));
							end
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// request side: accept at the rising edge, drive at the falling edge
	always @(posedge clk) begin
		op_t taken;
		outcome_t res;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			taken = '{req_ch.kind, req_ch.req_pages, req_ch.page_offset};
			res = allocator_outcome(taken);
			due_outcomes.push_back(res);
			kind_count[taken.kind]++;
			status_count[res.status]++;
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		op_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (op_queue.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
				nxt = op_queue.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= nxt.kind;
				req_ch.req_pages <= nxt.req_pages;
				req_ch.page_offset <= nxt.page_offset;
			end else begin
				req_ch.valid <= 1'b0;
				req_ch.kind <= 2'($urandom);
				req_ch.req_pages <= PW'($urandom);
				req_ch.page_offset <= OW'($urandom);
			end
		end
		req_taken = 1'b0;
	end

	// response side: ready at the falling edge, check at the rising edge
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_ch.ready <= steady || $urandom_range(99) >= 33;
		end
	end

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			responses++;
			if (due_outcomes.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %0d/%0d/%0d",
					$realtime, rsp_ch.status, rsp_ch.block_offset, rsp_ch.block_pages);
				fail_count++;
			end else begin
				exp = due_outcomes.pop_front();
				check_field("status", exp.status, rsp_ch.status);
				check_field("block_offset", exp.block_offset, rsp_ch.block_offset);
				check_field("block_pages", exp.block_pages, rsp_ch.block_pages);
			end
		end
	end

	task automatic push_op(input logic [1:0] kind, input int req_pages, input int page_offset);
		while (op_queue.size() >= 2)
			@(negedge clk);
		op_queue.push_back('{kind, PW'(req_pages), OW'(page_offset)});
	endtask

	// wait until every request has been answered, then let the engine go quiet
	task automatic settle();
		while (op_queue.size() > 0 || req_ch.valid || due_outcomes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pool(input logic [PW-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.pool_pages <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_pool(v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_ch.pool_pages <= PW'($urandom);
	endtask

	task automatic random_op();
		int pick, lg, k, hi, lo, idx;
		block_t blk;
		pick = $urandom_range(99);
		if (pick < 45) begin
			if ($urandom_range(99) < 5) begin
				push_op(bba_pkg::KIND_ALLOC, $urandom_range(bba_pkg::MAX_PAGES, pool_size),
					$urandom);
			end else begin
				lg = $clog2(pool_size);
				k = $urandom_range($urandom_range(lg, 0), 0);
				hi = 1 << k;
				lo = (k == 0) ? 0 : (hi >> 1) + 1;
				push_op(bba_pkg::KIND_ALLOC, $urandom_range(hi, lo), $urandom);
			end
		end else if (pick < 92 && held_blocks.size() > 0) begin
			// free or query a live block, sometimes by an offset inside it
			idx = $urandom_range(held_blocks.size() - 1);
			blk = held_blocks[idx];
			if ($urandom_range(99) < 30)
				blk.offset = blk.offset + OW'($urandom_range(blk.pages - 1));
			if (pick < 80) begin
				held_blocks.delete(idx);
				push_op(bba_pkg::KIND_FREE, $urandom, blk.offset);
			end else begin
				push_op(bba_pkg::KIND_QUERY, $urandom, blk.offset);
			end
		end else if (pick < 97) begin
			push_op($urandom_range(1) ? bba_pkg::KIND_FREE : bba_pkg::KIND_QUERY, $urandom,
				($urandom_range(1) ? $urandom_range(pool_size - 1) :
					$urandom_range(bba_pkg::MAX_PAGES - 1)));
		end else begin
			push_op(KIND_UNUSED, $urandom, $urandom);
		end
	endtask

	task automatic random_phase(input logic [PW-1:0] pool_v, input int count);
		settle();
		write_pool(pool_v);
		repeat (count) random_op();
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.pool_pages = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.req_pages = '0;
		req_ch.page_offset = '0;
		rsp_ch.ready = 1'b0;
		pool_size = bba_pkg::RESET_POOL;
		rebuild_tree();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full pool from reset
		push_op(bba_pkg::KIND_QUERY, 0, 0);
		push_op(bba_pkg::KIND_FREE, 0, 5);
		push_op(bba_pkg::KIND_ALLOC, 0, 0);
		push_op(bba_pkg::KIND_ALLOC, 1, 0);
		push_op(bba_pkg::KIND_ALLOC, 3, 0);
		push_op(bba_pkg::KIND_ALLOC, 1024, 0);
		push_op(bba_pkg::KIND_QUERY, 0, 1);
		push_op(bba_pkg::KIND_QUERY, 0, 5);
		push_op(bba_pkg::KIND_FREE, 0, 6);
		push_op(bba_pkg::KIND_FREE, 0, 0);
		push_op(bba_pkg::KIND_FREE, 0, 1);
		push_op(bba_pkg::KIND_ALLOC, 1024, 0);
		push_op(bba_pkg::KIND_QUERY, 0, 1023);
		push_op(bba_pkg::KIND_FREE, 2047, 1023);
		push_op(KIND_UNUSED, 2047, 1023);
		push_op(bba_pkg::KIND_ALLOC, 512, 0);
		push_op(bba_pkg::KIND_ALLOC, 513, 0);
		push_op(bba_pkg::KIND_ALLOC, 511, 0);
		push_op(bba_pkg::KIND_FREE, 0, 512);

		// single page pool
		settle();
		write_pool(1);
		push_op(bba_pkg::KIND_ALLOC, 0, 0);
		push_op(bba_pkg::KIND_ALLOC, 1, 0);
		push_op(bba_pkg::KIND_QUERY, 0, 0);
		push_op(bba_pkg::KIND_QUERY, 0, 1);
		push_op(bba_pkg::KIND_FREE, 0, 1023);
		push_op(bba_pkg::KIND_FREE, 0, 0);
		push_op(bba_pkg::KIND_FREE, 0, 0);

		// illegal sizes leave the single page pool in place
		settle();
		write_pool(0);
		write_pool(3);
		write_pool(1536);
		write_pool(2047);
		push_op(bba_pkg::KIND_QUERY, 0, 1);
		push_op(bba_pkg::KIND_ALLOC, 2, 0);
		push_op(bba_pkg::KIND_ALLOC, 1, 0);

		random_phase(2, 60);
		random_phase(16, 100);

		// hold the response side off while requests keep coming
		random_phase(1024, 50);
		@(posedge clk);
		rsp_hold = 400;
		repeat (60) random_op();
		settle();
		repeat (90) random_op();

		steady = 1'b1;
		random_phase(64, 100);
		settle();
		steady = 1'b0;

		random_phase(256, 160);

		settle();
		$display("Covered %0d allocs, %0d frees, %0d queries, %0d unused-kind requests",
			kind_count[bba_pkg::KIND_ALLOC], kind_count[bba_pkg::KIND_FREE],
			kind_count[bba_pkg::KIND_QUERY], kind_count[KIND_UNUSED]);
		$display("%0d responses, ok/no-space/not-allocated/out-of-pool %0d/%0d/%0d/%0d, %0d/%0d pool writes taken/rejected",
			responses, status_count[bba_pkg::ST_OK], status_count[bba_pkg::ST_NO_SPACE],
			status_count[bba_pkg::ST_NOT_ALLOC], status_count[bba_pkg::ST_OUT_POOL],
			pool_writes, pool_ignored);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("Timeout with %0d responses outstanding", due_outcomes.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
